// ----- design/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the framed Fletcher packet parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned FrameLenDefault = 64;

  localparam logic [7:0] HdrFirst  = 8'h59;
  localparam logic [7:0] HdrSecond = 8'h53;
  localparam logic [7:0] ByteMask  = 8'hff;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_RECV  = 2'd1,
    PH_CHECK = 2'd2,
    PH_HAND  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       byte_stored;
    logic [5:0] byte_position;
    logic [7:0] byte_value;
    logic       frame_ready;
    logic       checksum_bad;
  } res_t;

endpackage

// ----- design/sync_framed_fletcher_parser_unit.sv -----
// ----------------------------------------------------------------------------
// sync_framed_fletcher_parser_unit
// Hunts for the 0x59 0x53 header, reports frame bytes with their positions
// and checks the trailing 8-bit Fletcher sums of each frame.
// ----------------------------------------------------------------------------
// Result path: an accepted rx beat passes through the input register, then
//   through the step logic into the result register.
// Throughput: one byte per cycle unless a full result register is held by
//   !res_ready; the state update of the parser core is the only loop.
// Reset: rst (synchronous) empties both registers and puts the parser in
//   header hunt with cleared sums and previous byte.
module sync_framed_fletcher_parser_unit #(
  parameter int unsigned FRAME_LEN = sfp_pkg::FrameLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       byte_stored,
  output logic [5:0] byte_position,
  output logic [7:0] byte_value,
  output logic       frame_ready,
  output logic       checksum_bad
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;
  sfp_pkg::res_t step_res, res;

  assign advance  = in_valid && (!res_valid || res_ready);
  assign rx_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_ready) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  sfp_core #(
    .FRAME_LEN(FRAME_LEN)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rx_byte(in_byte),
    .res    (step_res)
  );

  // hold the result until taken; refill on each advance
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign byte_stored   = res.byte_stored;
  assign byte_position = res.byte_position;
  assign byte_value    = res.byte_value;
  assign frame_ready   = res.frame_ready;
  assign checksum_bad  = res.checksum_bad;

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($countones({byte_stored, frame_ready, checksum_bad}) <= 1))
    else $error("more than one result flag set");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !byte_stored) |-> (byte_position == 6'd0 && byte_value == 8'd0))
    else $error("position or value set on a beat with no stored byte");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("input stalled while result register is empty");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");

endmodule

// ----- design/sfp_core.sv -----
// ----------------------------------------------------------------------------
// sfp_core
// Parser state, running Fletcher sums and the per-byte step logic.
// ----------------------------------------------------------------------------
module sfp_core #(
  parameter int unsigned FRAME_LEN = sfp_pkg::FrameLenDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output sfp_pkg::res_t res
);

  localparam int unsigned PW = ($clog2(FRAME_LEN) > 6) ? $clog2(FRAME_LEN) : 6;
  localparam logic [PW-1:0] HighPos = PW'(FRAME_LEN - 2);
  localparam logic [PW-1:0] LastPos = PW'(FRAME_LEN - 1);
  localparam logic [PW-1:0] FirstPos = PW'(2);

  sfp_pkg::phase_t phase, phase_next;
  logic [7:0]    previous_byte;
  logic [PW-1:0] write_position, write_position_next;
  logic [7:0]    sum_first, sum_first_next;
  logic [7:0]    sum_second, sum_second_next;
  logic [7:0]    expected_high, expected_low;
  logic          load_high, load_low;
  logic [7:0]    sum_first_add;

  assign sum_first_add = sum_first + rx_byte;

  always_comb begin
    phase_next          = phase;
    write_position_next = write_position;
    sum_first_next      = sum_first;
    sum_second_next     = sum_second;
    load_high           = 1'b0;
    load_low            = 1'b0;
    res                 = '0;
    unique case (phase)
      sfp_pkg::PH_HUNT: begin
        if (previous_byte == sfp_pkg::HdrFirst && rx_byte == sfp_pkg::HdrSecond) begin
          res.byte_stored     = 1'b1;
          res.byte_position   = 6'd1;
          res.byte_value      = rx_byte;
          write_position_next = FirstPos;
          sum_first_next      = '0;
          sum_second_next     = '0;
          phase_next          = sfp_pkg::PH_RECV;
        end
      end
      sfp_pkg::PH_RECV: begin
        res.byte_stored   = 1'b1;
        res.byte_position = write_position[5:0];
        res.byte_value    = rx_byte;
        if (write_position < HighPos) begin
          sum_first_next  = sum_first_add;
          sum_second_next = sum_second + sum_first_add;
        end else if (write_position == HighPos) begin
          load_high = 1'b1;
        end else begin
          load_low = 1'b1;
        end
        write_position_next = write_position + 1'b1;
        // last frame byte: move on to the check beat
        if (write_position == LastPos) begin
          phase_next = sfp_pkg::PH_CHECK;
        end
      end
      sfp_pkg::PH_CHECK: begin
        if (sum_first == expected_high && sum_second == expected_low) begin
          phase_next = sfp_pkg::PH_HAND;
        end else begin
          res.checksum_bad = 1'b1;
          phase_next       = sfp_pkg::PH_HUNT;
        end
      end
      sfp_pkg::PH_HAND: begin
        res.frame_ready = 1'b1;
        phase_next      = sfp_pkg::PH_HUNT;
      end
      default: begin
        phase_next = sfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfp_pkg::PH_HUNT;
      previous_byte  <= '0;
      write_position <= '0;
      sum_first      <= '0;
      sum_second     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      previous_byte  <= rx_byte & sfp_pkg::ByteMask;
      write_position <= write_position_next;
      sum_first      <= sum_first_next;
      sum_second     <= sum_second_next;
    end
  end

  // expected sums are always written before the check reads them
  always_ff @(posedge clk) begin
    if (step && load_high) begin
      expected_high <= rx_byte;
    end
    if (step && load_low) begin
      expected_low <= rx_byte;
    end
  end

endmodule
